// File: rtl/qpc_pkg.sv
// ----------------------------------------------------------------------------
// qpc_pkg
// Types and constants shared by the quadrature position controller.
// ----------------------------------------------------------------------------
package qpc_pkg;

    localparam int GAIN_W     = 10;
    localparam int DRIVE_W    = 16;
    localparam int TARGET_W   = 32;
    localparam int POS_OUT_W  = 32;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 10'd75;
    localparam logic [DRIVE_W-1:0] LIMIT_RESET = 16'd5000;

    // duty = drive / 200 as (drive * 5243) >> 20, exact for drive <= 20000
    localparam logic [DRIVE_W-1:0] DUTY_FULL_SCALE = 16'd20000;
    localparam int                 DUTY_SHIFT      = 20;
    localparam int                 DUTY_PROD_W     = DRIVE_W + 13;
    localparam logic [12:0]        DUTY_RECIP      = 13'd5243;
    localparam int                 DUTY_Q_W        = 7;
    localparam logic [DUTY_Q_W-1:0] DUTY_FULL      = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN        = 1'b0,
        CFG_DRIVE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                 valid;
        logic [POS_OUT_W-1:0] pos;
        logic                 fwd;
        logic                 rev;
        logic                 big;
        logic [DRIVE_W-1:0]   mag;
    } t_err_stage;

    typedef struct packed {
        logic [POS_OUT_W-1:0]     pos;
        logic [DRIVE_W-1:0]       drive;
        logic                     fwd;
        logic                     rev;
        logic signed [DUTY_W-1:0] duty;
    } t_result;

endpackage

// File: rtl/qpc_if.sv
// ----------------------------------------------------------------------------
// qpc_if
// Valid/ready channels for encoder samples in and drive results out.
// ----------------------------------------------------------------------------
interface qpc_in_if;
    logic               valid;
    logic               ready;
    logic               phase_a;
    logic               phase_b;
    logic signed [31:0] target_position;

    modport source (output valid, phase_a, phase_b, target_position, input ready);
    modport sink   (input valid, phase_a, phase_b, target_position, output ready);
endinterface

interface qpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic [15:0]        drive_magnitude;
    logic               drive_forward;
    logic               drive_reverse;
    logic signed [7:0]  duty_percent;

    modport source (output valid, position, drive_magnitude, drive_forward,
                    drive_reverse, duty_percent, input ready);
    modport sink   (input valid, position, drive_magnitude, drive_forward,
                    drive_reverse, duty_percent, output ready);
endinterface

// File: rtl/quadrature_position_p_controller.sv
// ----------------------------------------------------------------------------
// quadrature_position_p_controller
// Quadrature decoder with proportional position control.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while the output side takes results;
// each accepted item passes through five registers (input register, counter
// and error, magnitude, gain multiply, duty) before its result is valid. The
// whole pipeline advances together, so input ready follows output ready
// whenever a result is held.
// Gain and drive limit may be written only while no item is in flight.
module quadrature_position_p_controller
    import qpc_pkg::*;
#(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    qpc_in_if.sink                i_in,
    qpc_out_if.source             o_out
);

    localparam int PW = POSITION_WIDTH;
    localparam int EW = ((PW > TARGET_W) ? PW : TARGET_W) + 1;

    logic                  w_adv;
    logic [GAIN_W-1:0]     r_gain;
    logic [DRIVE_W-1:0]    r_limit;

    logic                  r_last_a;
    logic                  r_last_b;
    logic [PW-1:0]         r_count;
    logic [PW-1:0]         n_count;

    logic                  r_v0;
    logic                  r_a0;
    logic                  r_b0;
    logic [TARGET_W-1:0]   r_tgt0;

    logic                  r_v1;
    logic [POS_OUT_W-1:0]  r_pos1;
    logic [EW-1:0]         r_diff1;

    logic                  r_v2;
    logic [POS_OUT_W-1:0]  r_pos2;
    logic                  r_fwd2;
    logic                  r_rev2;
    logic                  r_big2;
    logic [DRIVE_W-1:0]    r_mag2;
    t_err_stage            w_err2;

    logic [EW-1:0]         w_tgt_x;
    logic [EW-1:0]         w_pos_x;
    logic                  w_step;
    logic [EW-1:0]         w_abs;
    logic                  w_neg;

    logic                  w_res_valid;
    t_result               w_res;

    assign w_adv      = !w_res_valid || o_out.ready;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= GAIN_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:        r_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_DRIVE_LIMIT: r_limit <= i_cfg_wdata[DRIVE_W-1:0];
                default: ;
            endcase
        end
    end

    // counter step on any phase change
    assign w_step = (r_a0 != r_last_a) || (r_b0 != r_last_b);

    always_comb begin
        n_count = r_count;
        if (w_step) begin
            if (r_a0 == r_last_b) begin
                n_count = r_count - PW'(1);
            end else begin
                n_count = r_count + PW'(1);
            end
        end
    end

    assign w_tgt_x = {{(EW-TARGET_W){r_tgt0[TARGET_W-1]}}, r_tgt0};
    assign w_pos_x = {{(EW-PW){n_count[PW-1]}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
            r_count  <= '0;
        end else if (w_adv) begin
            r_v0 <= i_in.valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (r_v0) begin
                r_last_a <= r_a0;
                r_last_b <= r_b0;
                r_count  <= n_count;
            end
        end
    end

    assign w_neg = r_diff1[EW-1];
    assign w_abs = w_neg ? (EW'(0) - r_diff1) : r_diff1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a0    <= i_in.phase_a;
            r_b0    <= i_in.phase_b;
            r_tgt0  <= i_in.target_position;
            r_pos1  <= w_pos_x[POS_OUT_W-1:0];
            r_diff1 <= w_tgt_x - w_pos_x;
            r_pos2  <= r_pos1;
            r_fwd2  <= !w_neg && (r_diff1 != '0);
            r_rev2  <= w_neg;
            r_big2  <= |w_abs[EW-1:DRIVE_W];
            r_mag2  <= w_abs[DRIVE_W-1:0];
        end
    end

    assign w_err2 = '{r_v2, r_pos2, r_fwd2, r_rev2, r_big2, r_mag2};

    qpc_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_gain  (r_gain),
        .i_limit (r_limit),
        .i_err   (w_err2),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    assign o_out.valid           = w_res_valid;
    assign o_out.position        = w_res.pos;
    assign o_out.drive_magnitude = w_res.drive;
    assign o_out.drive_forward   = w_res.fwd;
    assign o_out.drive_reverse   = w_res.rev;
    assign o_out.duty_percent    = w_res.duty;

endmodule

// File: rtl/qpc_drive.sv
// ----------------------------------------------------------------------------
// qpc_drive
// Drive back end: gain multiply with saturation, then duty percentage.
// ----------------------------------------------------------------------------
module qpc_drive
    import qpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [GAIN_W-1:0]   i_gain,
    input  logic [DRIVE_W-1:0]  i_limit,
    input  t_err_stage          i_err,
    output logic                o_valid,
    output t_result             o_res
);

    logic                     r_v3;
    logic [POS_OUT_W-1:0]     r_pos3;
    logic                     r_fwd3;
    logic                     r_rev3;
    logic [DRIVE_W-1:0]       r_drive3;
    logic                     r_v4;
    t_result                  r_res;

    logic [GAIN_W+DRIVE_W-1:0] w_prod;
    logic [DRIVE_W-1:0]        n_drive;
    logic [DUTY_PROD_W-1:0]    w_duty_prod;
    logic [DUTY_Q_W-1:0]       w_duty_q;
    logic [DUTY_W-1:0]         n_duty;

    assign w_prod = (GAIN_W+DRIVE_W)'(i_gain) * (GAIN_W+DRIVE_W)'(i_err.mag);

    always_comb begin
        if (i_gain == '0) begin
            n_drive = '0;
        end else if (i_err.big) begin
            n_drive = i_limit;
        end else if (w_prod > (GAIN_W+DRIVE_W)'(i_limit)) begin
            n_drive = i_limit;
        end else begin
            n_drive = w_prod[DRIVE_W-1:0];
        end
    end

    assign w_duty_prod = DUTY_PROD_W'(r_drive3) * DUTY_PROD_W'(DUTY_RECIP);

    always_comb begin
        if (r_drive3 > DUTY_FULL_SCALE) begin
            w_duty_q = DUTY_FULL;
        end else begin
            w_duty_q = w_duty_prod[DUTY_SHIFT +: DUTY_Q_W];
        end
        if (r_rev3) begin
            n_duty = DUTY_W'(0) - DUTY_W'(w_duty_q);
        end else begin
            n_duty = DUTY_W'(w_duty_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v3 <= i_err.valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pos3       <= i_err.pos;
            r_fwd3       <= i_err.fwd;
            r_rev3       <= i_err.rev;
            r_drive3     <= n_drive;
            r_res.pos    <= r_pos3;
            r_res.drive  <= r_drive3;
            r_res.fwd    <= r_fwd3;
            r_res.rev    <= r_rev3;
            r_res.duty   <= n_duty;
        end
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

endmodule

// File: rtl/qpc_checker.sv
// ----------------------------------------------------------------------------
// qpc_checker
// Port-level checks on the result channel of the position controller.
// ----------------------------------------------------------------------------
module qpc_checker
    import qpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_ready,
    input  logic [POS_OUT_W-1:0]     i_pos,
    input  logic [DRIVE_W-1:0]       i_drive,
    input  logic                     i_fwd,
    input  logic                     i_rev,
    input  logic signed [DUTY_W-1:0] i_duty
);

    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !(i_fwd && i_rev))
        else $error("forward and reverse both set");

    a_zero_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_fwd && !i_rev) |-> (i_drive == '0 && i_duty == '0))
        else $error("drive present with zero error");

    a_full_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_fwd && i_drive > DUTY_FULL_SCALE) |-> (i_duty == 8'sd100))
        else $error("duty not full scale");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_pos) && $stable(i_drive) && $stable(i_duty)))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

endmodule

bind quadrature_position_p_controller qpc_checker u_qpc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_pos   (o_out.position),
    .i_drive (o_out.drive_magnitude),
    .i_fwd   (o_out.drive_forward),
    .i_rev   (o_out.drive_reverse),
    .i_duty  (o_out.duty_percent)
);
